@@ design/jpeg_dht_canonical_code_gen_unit_assert.svh @@
// Assertion macros for the DHT code generator.
`ifndef JPEG_DHT_CANONICAL_CODE_GEN_UNIT_ASSERT_SVH
`define JPEG_DHT_CANONICAL_CODE_GEN_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define JDHT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("jdht: implication check failed");
`define JDHT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("jdht: next-cycle check failed");
`else
`define JDHT_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define JDHT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ design/jdht_pkg.sv @@
package jdht_pkg;

	typedef logic [2:0] step_t;

	localparam step_t STEP_LEN_HI  = 3'd0;
	localparam step_t STEP_LEN_LO  = 3'd1;
	localparam step_t STEP_CLASS   = 3'd2;
	localparam step_t STEP_COUNTS  = 3'd3;
	localparam step_t STEP_START   = 3'd4;
	localparam step_t STEP_ADVANCE = 3'd5;
	localparam step_t STEP_SYMBOL  = 3'd6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LEN_HI,
		OP_LEN_LO,
		OP_CLASS,
		OP_COUNT,
		OP_START,
		OP_ADVANCE,
		OP_SYMBOL
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_MORE_COUNTS,
		C_EMPTY,
		C_ADVANCE,
		C_LAST
	} cond_t;

	typedef struct packed {
		op_t   op;
		logic  wait_in;
		logic  wait_out;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ctrl_t;

	typedef struct packed {
		logic more_counts;
		logic empty;
		logic advance;
		logic last;
	} flags_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_LEN = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	localparam logic [15:0] HDR_BYTES = 16'd19;
	localparam logic [4:0]  ROWS      = 5'd16;

	// control store
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		case (s)
			STEP_LEN_HI:  w = '{OP_LEN_HI,  1'b1, 1'b0, C_ALWAYS,      STEP_LEN_LO,  STEP_LEN_LO};
			STEP_LEN_LO:  w = '{OP_LEN_LO,  1'b1, 1'b0, C_ALWAYS,      STEP_CLASS,   STEP_CLASS};
			STEP_CLASS:   w = '{OP_CLASS,   1'b1, 1'b0, C_ALWAYS,      STEP_COUNTS,  STEP_COUNTS};
			STEP_COUNTS:  w = '{OP_COUNT,   1'b1, 1'b0, C_MORE_COUNTS, STEP_COUNTS,  STEP_START};
			STEP_START:   w = '{OP_START,   1'b0, 1'b1, C_EMPTY,       STEP_LEN_HI,  STEP_ADVANCE};
			STEP_ADVANCE: w = '{OP_ADVANCE, 1'b0, 1'b0, C_ADVANCE,     STEP_ADVANCE, STEP_SYMBOL};
			STEP_SYMBOL:  w = '{OP_SYMBOL,  1'b1, 1'b1, C_LAST,        STEP_LEN_HI,  STEP_ADVANCE};
			default:      w = '{OP_NOP,     1'b0, 1'b0, C_ALWAYS,      STEP_LEN_HI,  STEP_LEN_HI};
		endcase
		return w;
	endfunction

endpackage

@@ design/jdht_seq.sv @@
module jdht_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  jdht_pkg::flags_t flags,
	input  logic           in_valid,
	input  logic           out_free,
	output jdht_pkg::ctrl_t  ctrl,
	output logic           go,
	output logic           taken
);
	import jdht_pkg::*;

	step_t pc_q;
	step_t pc_d;

	assign ctrl = ucode(pc_q);

	// a step holds while its word or its result slot is not available
	assign go = !((ctrl.wait_in && !in_valid) || (ctrl.wait_out && !out_free));

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:      taken = 1'b1;
			C_MORE_COUNTS: taken = flags.more_counts;
			C_EMPTY:       taken = flags.empty;
			C_ADVANCE:     taken = flags.advance;
			C_LAST:        taken = flags.last;
			default:       taken = 1'b0;
		endcase
	end

	always_comb begin
		if (!go) begin
			pc_d = pc_q;
		end else if (taken) begin
			pc_d = ctrl.tgt_t;
		end else begin
			pc_d = ctrl.tgt_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LEN_HI;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

@@ design/jpeg_dht_canonical_code_gen_unit.sv @@
// channel | signals                      | direction | word
// in      | in_valid, in_stall, byte_in  | sink      | one segment byte
// out     | out_valid, out_stall, fields | source    | one code result
//
// Each header byte is one step. A symbol byte is one symbol step plus one
// step in the row walk, plus one more per code length stepped over; the unit
// takes no new symbol byte until the walk has found the next row.
// The sixteenth count byte is followed by a start step and, if needed, the walk.
// Reset returns to waiting for the length high byte; count rows are not cleared.
// A held result in the output register stalls symbol bytes and the start step.
module jpeg_dht_canonical_code_gen_unit #(
	parameter int MAX_CODE_LENGTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  symbol,
	output logic [15:0] code,
	output logic [4:0]  code_length,
	output logic [3:0]  table_class,
	output logic [3:0]  table_id,
	output logic        symbol_valid,
	output logic        last,
	output logic [1:0]  status
);
	import jdht_pkg::*;

	`include "jpeg_dht_canonical_code_gen_unit_assert.svh"

	localparam logic [4:0]  MAX_LEN  = 5'(MAX_CODE_LENGTH);
	localparam logic [17:0] CODE_SAT = 18'h10000;

	ctrl_t  ctrl;
	flags_t flags;
	logic   go;
	logic   taken;
	logic   out_free;
	logic   in_acc;
	logic   out_load;

	logic [15:0] decl_len_q;
	logic [7:0]  row_counts_q [16];
	logic [3:0]  cnt_idx_q;
	logic [11:0] total_q;
	logic [11:0] seen_q;
	logic [4:0]  cur_len_q;
	logic [7:0]  left_q;
	logic [16:0] next_code_q;
	logic [7:0]  class_id_q;

	logic        out_valid_q;
	logic [7:0]  symbol_q;
	logic [15:0] code_q;
	logic [4:0]  len_q;
	logic [7:0]  cls_q;
	logic        sym_valid_q;
	logic        last_q;
	logic [1:0]  status_q;

	logic [7:0]  row_rd;
	logic [11:0] seen_inc;
	logic [17:0] shl_wide;
	logic [17:0] inc_wide;
	logic [16:0] code_shl;
	logic [16:0] code_inc;
	logic        over;
	logic        len_bad;
	logic [1:0]  sym_status;

	jdht_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags    (flags),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctrl     (ctrl),
		.go       (go),
		.taken    (taken)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !(ctrl.wait_in && (!ctrl.wait_out || out_free));
	assign in_acc   = in_valid && !in_stall;

	assign row_rd   = row_counts_q[cur_len_q[3:0]];
	assign seen_inc = seen_q + 12'd1;

	assign flags.more_counts = (cnt_idx_q != 4'hF);
	assign flags.empty       = (total_q == 12'd0);
	assign flags.advance     = (left_q == 8'd0) && (cur_len_q < ROWS);
	assign flags.last        = (seen_inc >= total_q);

	// running code saturates so an overflow sticks for the segment
	assign shl_wide = {next_code_q, 1'b0};
	assign inc_wide = {1'b0, next_code_q} + 18'd1;
	assign code_shl = (shl_wide > CODE_SAT) ? CODE_SAT[16:0] : shl_wide[16:0];
	assign code_inc = (inc_wide > CODE_SAT) ? CODE_SAT[16:0] : inc_wide[16:0];

	assign over = (cur_len_q > MAX_LEN) || (cur_len_q == 5'd0) ||
		((next_code_q >> cur_len_q) != 17'd0);
	assign len_bad    = (decl_len_q != ({4'd0, total_q} + HDR_BYTES));
	assign sym_status = (flags.last && len_bad) ? ST_LEN : (over ? ST_OVF : ST_OK);

	assign out_load = go && ((ctrl.op == OP_START && flags.empty) || ctrl.op == OP_SYMBOL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_len_q  <= '0;
			cnt_idx_q   <= '0;
			total_q     <= '0;
			seen_q      <= '0;
			cur_len_q   <= '0;
			left_q      <= '0;
			next_code_q <= '0;
			class_id_q  <= '0;
		end else if (go) begin
			case (ctrl.op)
				OP_LEN_HI: begin
					decl_len_q <= {8'd0, byte_in};
				end
				OP_LEN_LO: begin
					decl_len_q <= {decl_len_q[7:0], byte_in};
				end
				OP_CLASS: begin
					class_id_q <= byte_in;
					cnt_idx_q  <= '0;
					total_q    <= '0;
				end
				OP_COUNT: begin
					total_q   <= total_q + {4'd0, byte_in};
					cnt_idx_q <= cnt_idx_q + 4'd1;
				end
				OP_START: begin
					seen_q      <= '0;
					cur_len_q   <= '0;
					next_code_q <= '0;
					left_q      <= '0;
				end
				OP_ADVANCE: begin
					if (taken) begin
						cur_len_q   <= cur_len_q + 5'd1;
						next_code_q <= code_shl;
						left_q      <= row_rd;
					end
				end
				OP_SYMBOL: begin
					seen_q <= seen_inc;
					if (!flags.last) begin
						next_code_q <= code_inc;
						if (left_q != 8'd0) begin
							left_q <= left_q - 8'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// count rows: written by the count bytes before any read
	always_ff @(posedge clk) begin
		if (go && ctrl.op == OP_COUNT) begin
			row_counts_q[cnt_idx_q] <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cls_q <= class_id_q;
			if (ctrl.op == OP_SYMBOL) begin
				symbol_q    <= byte_in;
				code_q      <= over ? 16'd0 : next_code_q[15:0];
				len_q       <= cur_len_q;
				sym_valid_q <= 1'b1;
				last_q      <= flags.last;
				status_q    <= sym_status;
			end else begin
				symbol_q    <= '0;
				code_q      <= '0;
				len_q       <= '0;
				sym_valid_q <= 1'b0;
				last_q      <= 1'b1;
				status_q    <= (decl_len_q == HDR_BYTES) ? ST_OK : ST_LEN;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol       = symbol_q;
	assign code         = code_q;
	assign code_length  = len_q;
	assign table_class  = cls_q[7:4];
	assign table_id     = cls_q[3:0];
	assign symbol_valid = sym_valid_q;
	assign last         = last_q;
	assign status       = status_q;

	`JDHT_ASSERT_IMPLY(a_len_range, clk, arst_n, 1'b1, cur_len_q <= ROWS)
	`JDHT_ASSERT_NEXT(a_sym_result, clk, arst_n, in_acc && ctrl.op == OP_SYMBOL, out_valid_q)
	`JDHT_ASSERT_IMPLY(a_row_ready, clk, arst_n, ctrl.op == OP_SYMBOL, left_q != 8'd0 || cur_len_q == ROWS)
	`JDHT_ASSERT_IMPLY(a_marker_last, clk, arst_n, out_valid_q && !sym_valid_q, last_q && len_q == 5'd0)

endmodule

@@ bench/jpeg_dht_canonical_code_gen_unit_tb.sv @@
module jpeg_dht_canonical_code_gen_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN        = 16;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 200;

	typedef enum logic [2:0] {
		SEG_LEN_HI,
		SEG_LEN_LO,
		SEG_CLASS,
		SEG_COUNTS,
		SEG_SYMBOLS
	} seg_phase_t;

	typedef struct packed {
		logic [7:0]  symbol;
		logic [15:0] code;
		logic [4:0]  code_length;
		logic [3:0]  table_class;
		logic [3:0]  table_id;
		logic        symbol_valid;
		logic        last;
		logic [1:0]  status;
	} code_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  res_symbol;
	logic [15:0] res_code;
	logic [4:0]  res_code_length;
	logic [3:0]  res_table_class;
	logic [3:0]  res_table_id;
	logic        res_symbol_valid;
	logic        res_last;
	logic [1:0]  res_status;

	// predicted code words, oldest first
	code_word_t code_q[$];

	// predictor state
	seg_phase_t  seg_phase;
	logic [15:0] seg_length;
	logic [7:0]  row_count[16];
	logic [3:0]  count_pos;
	logic [11:0] sym_total;
	logic [11:0] sym_seen;
	logic [4:0]  cur_len;
	logic [7:0]  row_left;
	logic [16:0] run_code;
	logic [7:0]  class_id;

	int mismatches;
	int bytes_sent;
	int idle_cycles;
	int hold_left;
	bit quiet;

	jpeg_dht_canonical_code_gen_unit #(
		.MAX_CODE_LENGTH(MAX_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.symbol(res_symbol),
		.code(res_code),
		.code_length(res_code_length),
		.table_class(res_table_class),
		.table_id(res_table_id),
		.symbol_valid(res_symbol_valid),
		.last(res_last),
		.status(res_status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [16:0] clamp_code(int v);
		return (v > 'h10000) ? 17'h10000 : 17'(v);
	endfunction

	// step to the next populated code length, shifting the code per step
	function automatic void walk_rows();
		while (row_left == 8'd0 && cur_len < 5'd16) begin
			cur_len++;
			run_code = clamp_code(int'(run_code) << 1);
			row_left = row_count[4'(cur_len - 5'd1)];
		end
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		code_word_t w;
		logic ovf;
		logic [1:0] st;
		case (seg_phase)
			SEG_LEN_LO: begin
				seg_length = {seg_length[7:0], b};
				seg_phase = SEG_CLASS;
			end
			SEG_CLASS: begin
				class_id = b;
				count_pos = 4'd0;
				sym_total = 12'd0;
				seg_phase = SEG_COUNTS;
			end
			SEG_COUNTS: begin
				row_count[count_pos] = b;
				sym_total = sym_total + 12'(b);
				if (count_pos != 4'd15) begin
					count_pos++;
				end else begin
					count_pos = 4'd0;
					sym_seen = 12'd0;
					if (sym_total == 12'd0) begin
						seg_phase = SEG_LEN_HI;
						w = '{symbol: 8'd0, code: 16'd0, code_length: 5'd0,
							table_class: class_id[7:4], table_id: class_id[3:0],
							symbol_valid: 1'b0, last: 1'b1,
							status: (seg_length == jdht_pkg::HDR_BYTES) ?
								jdht_pkg::ST_OK : jdht_pkg::ST_LEN};
						code_q.push_back(w);
					end else begin
						cur_len = 5'd0;
						run_code = 17'd0;
						row_left = 8'd0;
						walk_rows();
						seg_phase = SEG_SYMBOLS;
					end
				end
			end
			SEG_SYMBOLS: begin
				ovf = (int'(cur_len) > MAX_LEN) || cur_len == 5'd0 ||
					int'(run_code) >= (1 << cur_len);
				st = ovf ? jdht_pkg::ST_OVF : jdht_pkg::ST_OK;
				w = '{symbol: b, code: ovf ? 16'd0 : run_code[15:0], code_length: cur_len,
					table_class: class_id[7:4], table_id: class_id[3:0],
					symbol_valid: 1'b1, last: 1'b0, status: 2'd0};
				sym_seen++;
				if (sym_seen >= sym_total) begin
					// length mismatch wins over overflow
					if (int'(seg_length) != int'(jdht_pkg::HDR_BYTES) + int'(sym_total))
						st = jdht_pkg::ST_LEN;
					w.last = 1'b1;
					seg_phase = SEG_LEN_HI;
				end else begin
					run_code = clamp_code(int'(run_code) + 1);
					if (row_left != 8'd0)
						row_left--;
					walk_rows();
				end
				w.status = st;
				code_q.push_back(w);
			end
			default: begin
				seg_length = {8'd0, b};
				seg_phase = SEG_LEN_LO;
			end
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_words
		code_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (code_q.size() == 0) begin
				$error("unexpected word: symbol 0x%0h code 0x%0h", res_symbol, res_code);
				mismatches++;
			end else begin
				want = code_q.pop_front();
				check_field("symbol", want.symbol, res_symbol);
				check_field("code", want.code, res_code);
				check_field("code_length", want.code_length, res_code_length);
				check_field("table_class", want.table_class, res_table_class);
				check_field("table_id", want.table_id, res_table_id);
				check_field("symbol_valid", want.symbol_valid, res_symbol_valid);
				check_field("last", want.last, res_last);
				check_field("status", want.status, res_status);
			end
		end
	end

	// receiver stall: random, quiet stretches, and long hold-offs on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 30);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (in_stall);
		predict_byte(b);
		bytes_sent++;
	endtask

	// decl < 0 means the correct declared length
	task automatic send_segment(input logic [7:0] cls, input int rows_in[16], input int decl);
		int total;
		int k;
		logic [15:0] len16;
		total = 0;
		foreach (rows_in[i])
			total += rows_in[i];
		len16 = (decl < 0) ? 16'(int'(jdht_pkg::HDR_BYTES) + total) : 16'(decl);
		send_byte(len16[15:8]);
		send_byte(len16[7:0]);
		send_byte(cls);
		foreach (rows_in[i])
			send_byte(8'(rows_in[i]));
		for (k = 0; k < total; k++)
			send_byte((k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom));
	endtask

	// sender holds off until every predicted word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (code_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_tables();
		int zero[16];
		zero = '{default: 0};
		send_segment(8'h00, zero, -1);
		send_segment(8'hFF, zero, 16'h0000);
		send_segment(8'h13, zero, 16'hFFFF);
		wait_drained();
	endtask

	task automatic test_standard_tables();
		send_segment(8'h00, '{0, 1, 5, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0}, -1);
		send_segment(8'h11, '{2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, -1);
		// single code at length 16, walk steps over every empty row
		send_segment(8'h01, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1}, -1);
		wait_drained();
	endtask

	task automatic test_code_overflow();
		send_segment(8'h10, '{3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, -1);
		// runs past 4 bits, then the shift to 16 saturates the code
		send_segment(8'h11, '{0, 0, 0, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2}, -1);
		// overflow on the last word together with a bad length
		send_segment(8'h02, '{3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 19);
		wait_drained();
	endtask

	task automatic test_length_mismatch();
		send_segment(8'h00, '{0, 1, 5, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0}, 32);
		send_segment(8'h01, '{0, 1, 5, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0}, 30);
		wait_drained();
	endtask

	task automatic test_full_row_backpressure();
		hold_left = HOLD_CYCLES;
		send_segment(8'h10, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255}, -1);
		wait_drained();
	endtask

	task automatic test_random_segments();
		int rows[16];
		int n;
		int k;
		int kind;
		int total;
		int decl;
		int pick;
		int start;
		logic [7:0] cls;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			quiet = (bytes_sent - start >= 50) && (bytes_sent - start < 150);
			rows = '{default: 0};
			kind = $urandom_range(99);
			if (kind >= 5) begin
				n = $urandom_range(1, 10);
				for (k = 0; k < n; k++) begin
					pick = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 7);
					rows[pick]++;
				end
			end
			if (kind >= 5 && kind < 12)
				rows[0] += $urandom_range(3, 5);
			if (kind >= 12 && kind < 16)
				rows[$urandom_range(15)] += $urandom_range(16, 40);
			total = 0;
			foreach (rows[i])
				total += rows[i];
			pick = $urandom_range(99);
			if (pick < 85)
				decl = -1;
			else if (pick < 92)
				decl = int'(jdht_pkg::HDR_BYTES) + total + (($urandom_range(1) == 0) ? -1 : 1);
			else
				decl = $urandom_range(65535);
			cls = ($urandom_range(9) < 7) ?
				{3'b000, 1'($urandom_range(1)), 2'b00, 2'($urandom_range(3))} : 8'($urandom);
			send_segment(cls, rows, decl);
			if ($urandom_range(9) == 0)
				wait_drained();
		end
		quiet = 1'b0;
	endtask

	initial begin
		in_valid = 1'b0;
		byte_in = 8'd0;
		arst_n = 1'b0;
		mismatches = 0;
		bytes_sent = 0;
		idle_cycles = 0;
		hold_left = 0;
		quiet = 1'b0;
		seg_phase = SEG_LEN_HI;
		seg_length = 16'd0;
		count_pos = 4'd0;
		sym_total = 12'd0;
		sym_seen = 12'd0;
		cur_len = 5'd0;
		row_left = 8'd0;
		run_code = 17'd0;
		class_id = 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tables();
		test_standard_tables();
		test_code_overflow();
		test_length_mismatch();
		test_full_row_backpressure();
		test_random_segments();
		wait_drained();

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ jpeg_dht_canonical_code_gen_unit.f @@
+incdir+design
design/jdht_pkg.sv
design/jdht_seq.sv
design/jpeg_dht_canonical_code_gen_unit.sv
bench/jpeg_dht_canonical_code_gen_unit_tb.sv
